// ===== src/m6502_pkg.sv =====
// Shared types, constants and helpers for the 6502 subset execute block.
package m6502_pkg;

    localparam int MEM_DEPTH   = 65536;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]        P_RESET    = 8'h24;
    localparam logic [7:0]        SP_RESET   = 8'hFD;
    localparam logic [7:0]        FLAG_N     = 8'h80;
    localparam logic [7:0]        FLAG_B     = 8'h10;
    localparam logic [7:0]        FLAG_I     = 8'h04;
    localparam logic [7:0]        FLAG_Z     = 8'h02;
    localparam logic [7:0]        PUSH_P_SET = 8'h30;
    localparam logic [7:0]        STACK_PAGE = 8'h01;
    localparam logic [ADDR_W-1:0] VEC_LO     = 16'hFFFE;
    localparam logic [ADDR_W-1:0] VEC_HI     = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_LDA  = 3'd0,
        OP_STA  = 3'd1,
        OP_TAX  = 3'd2,
        OP_INX  = 3'd3,
        OP_BRK  = 3'd4,
        OP_POKE = 3'd5,
        OP_PEEK = 3'd6,
        OP_NONE = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_IMM  = 3'd0,
        MODE_ZP   = 3'd1,
        MODE_ABS  = 3'd2,
        MODE_ABSX = 3'd3,
        MODE_ABSY = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        K_NOP,
        K_FAULT,
        K_LDA_IMM,
        K_LDA_MEM,
        K_STA,
        K_TAX,
        K_INX,
        K_BRK,
        K_POKE,
        K_PEEK
    } kind_t;

    typedef enum logic [1:0] {
        IDX_NONE,
        IDX_X,
        IDX_Y
    } idx_sel_t;

    typedef struct packed {
        kind_t       kind;
        idx_sel_t    idx_sel;
        logic        zp;
        logic [15:0] operand;
        logic [7:0]  host_data;
    } uop_t;

    typedef enum logic [2:0] {
        B_DISPATCH,
        B_RD_WAIT,
        B_BRK_LO,
        B_BRK_P,
        B_BRK_VLO,
        B_BRK_VHI,
        B_BRK_DONE
    } back_state_t;

    function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p & ~(FLAG_Z | FLAG_N);
        if (v == 8'h00) r = r | FLAG_Z;
        if (v[7]) r = r | FLAG_N;
        return r;
    endfunction

endpackage

// ===== src/m6502_front.sv =====
// Front end: accept instruction transfers and classify them into queue entries.
module m6502_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: opcode[2:0], mode[5:3], operand[21:6], host_data[29:22], zero pad
    input  logic [m6502_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output m6502_pkg::uop_t                q_uop
);
    import m6502_pkg::*;

    opcode_t opc;
    mode_t   mode;

    assign opc      = opcode_t'(s_tdata[2:0]);
    assign mode     = mode_t'(s_tdata[5:3]);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_uop.kind      = K_NOP;
        q_uop.idx_sel   = IDX_NONE;
        q_uop.zp        = 1'b0;
        q_uop.operand   = s_tdata[21:6];
        q_uop.host_data = s_tdata[29:22];
        case (opc)
            OP_LDA, OP_STA: begin
                q_uop.kind = (opc == OP_LDA) ? K_LDA_MEM : K_STA;
                case (mode)
                    MODE_IMM: begin
                        q_uop.kind = (opc == OP_LDA) ? K_LDA_IMM : K_FAULT;
                    end
                    MODE_ZP:   q_uop.zp = 1'b1;
                    MODE_ABS:  q_uop.idx_sel = IDX_NONE;
                    MODE_ABSX: q_uop.idx_sel = IDX_X;
                    MODE_ABSY: q_uop.idx_sel = IDX_Y;
                    default:   q_uop.kind = K_FAULT;
                endcase
            end
            OP_TAX:  q_uop.kind = K_TAX;
            OP_INX:  q_uop.kind = K_INX;
            OP_BRK:  q_uop.kind = K_BRK;
            OP_POKE: q_uop.kind = K_POKE;
            OP_PEEK: q_uop.kind = K_PEEK;
            default: q_uop.kind = K_NOP;
        endcase
    end

endmodule

// ===== src/m6502_queue.sv =====
// Small FIFO of classified instructions between front and back.
module m6502_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  m6502_pkg::uop_t push_uop,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output m6502_pkg::uop_t head_uop
);
    import m6502_pkg::*;

    uop_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_uop   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_uop;
    end

endmodule

// ===== src/m6502_back.sv =====
// Back end: register file, byte memory, execute sequencer and result register.
module m6502_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [7:0]                     index_y,
    input  logic                           q_valid,
    input  m6502_pkg::uop_t                q_uop,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: acc[7:0], x_reg[15:8], flags[23:16], prog_counter[39:24],
    //        stack_ptr[47:40], read_byte[55:48], fault[56], zero pad
    output logic [m6502_pkg::M_DATA_W-1:0] m_tdata
);
    import m6502_pkg::*;

    logic [7:0] mem [MEM_DEPTH];

    back_state_t state_reg, state_next;
    kind_t       cur_kind_reg, cur_kind_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  p_reg, p_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  sp_reg, sp_next;
    logic [15:0] ret_reg, ret_next;
    logic [7:0]  vlo_reg, vlo_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [7:0]  mem_rdata_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic              out_free;
    logic              out_load;
    logic [7:0]        res_rbyte;
    logic              res_fault;
    logic [7:0]        idx_val;
    logic [ADDR_W-1:0] ea;
    logic [7:0]        p_brk;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == B_DISPATCH) && q_valid && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign p_brk    = p_reg | FLAG_B | FLAG_I;

    always_comb begin
        case (q_uop.idx_sel)
            IDX_X:   idx_val = x_reg;
            IDX_Y:   idx_val = index_y;
            default: idx_val = 8'h00;
        endcase
        if (q_uop.zp) ea = {8'h00, q_uop.operand[7:0]};
        else          ea = q_uop.operand + {8'h00, idx_val};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_DISPATCH: begin
                if (q_pop) begin
                    case (q_uop.kind)
                        K_LDA_MEM, K_PEEK: state_next = B_RD_WAIT;
                        K_BRK:             state_next = B_BRK_LO;
                        default:           state_next = B_DISPATCH;
                    endcase
                end
            end
            B_RD_WAIT:  if (out_free) state_next = B_DISPATCH;
            B_BRK_LO:   state_next = B_BRK_P;
            B_BRK_P:    state_next = B_BRK_VLO;
            B_BRK_VLO:  state_next = B_BRK_VHI;
            B_BRK_VHI:  state_next = B_BRK_DONE;
            B_BRK_DONE: if (out_free) state_next = B_DISPATCH;
            default:    state_next = B_DISPATCH;
        endcase
    end

    always_comb begin
        cur_kind_next = cur_kind_reg;
        a_next        = a_reg;
        x_next        = x_reg;
        p_next        = p_reg;
        pc_next       = pc_reg;
        sp_next       = sp_reg;
        ret_next      = ret_reg;
        vlo_next      = vlo_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = ea;
        mem_wdata     = a_reg;
        out_load      = 1'b0;
        res_rbyte     = 8'h00;
        res_fault     = 1'b0;
        case (state_reg)
            B_DISPATCH: begin
                if (q_pop) begin
                    cur_kind_next = q_uop.kind;
                    case (q_uop.kind)
                        K_LDA_IMM: begin
                            a_next   = q_uop.operand[7:0];
                            p_next   = set_zn(p_reg, q_uop.operand[7:0]);
                            out_load = 1'b1;
                        end
                        K_LDA_MEM: mem_re = 1'b1;
                        K_STA: begin
                            mem_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        K_TAX: begin
                            x_next   = a_reg;
                            p_next   = set_zn(p_reg, a_reg);
                            out_load = 1'b1;
                        end
                        K_INX: begin
                            x_next   = x_reg + 8'd1;
                            p_next   = set_zn(p_reg, x_reg + 8'd1);
                            out_load = 1'b1;
                        end
                        K_BRK: begin
                            ret_next  = pc_reg + 16'd2;
                            mem_we    = 1'b1;
                            mem_addr  = {STACK_PAGE, sp_reg};
                            mem_wdata = ret_next[15:8];
                            sp_next   = sp_reg - 8'd1;
                        end
                        K_POKE: begin
                            mem_we    = 1'b1;
                            mem_addr  = q_uop.operand;
                            mem_wdata = q_uop.host_data;
                            out_load  = 1'b1;
                        end
                        K_PEEK: begin
                            mem_re   = 1'b1;
                            mem_addr = q_uop.operand;
                        end
                        K_FAULT: begin
                            res_fault = 1'b1;
                            out_load  = 1'b1;
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            B_RD_WAIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (cur_kind_reg == K_LDA_MEM) begin
                        a_next = mem_rdata_reg;
                        p_next = set_zn(p_reg, mem_rdata_reg);
                    end else begin
                        res_rbyte = mem_rdata_reg;
                    end
                end
            end
            B_BRK_LO: begin
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, sp_reg};
                mem_wdata = ret_reg[7:0];
                sp_next   = sp_reg - 8'd1;
            end
            B_BRK_P: begin
                p_next    = p_brk;
                mem_we    = 1'b1;
                mem_addr  = {STACK_PAGE, sp_reg};
                mem_wdata = p_brk | PUSH_P_SET;
                sp_next   = sp_reg - 8'd1;
            end
            B_BRK_VLO: begin
                mem_re   = 1'b1;
                mem_addr = VEC_LO;
            end
            B_BRK_VHI: begin
                mem_re   = 1'b1;
                mem_addr = VEC_HI;
                vlo_next = mem_rdata_reg;
            end
            B_BRK_DONE: begin
                if (out_free) begin
                    pc_next  = {mem_rdata_reg, vlo_reg};
                    out_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tdata_next = {7'd0, res_fault, res_rbyte, sp_next, pc_next,
                            p_next, x_next, a_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_DISPATCH;
            cur_kind_reg <= K_NOP;
            a_reg        <= 8'h00;
            x_reg        <= 8'h00;
            p_reg        <= P_RESET;
            pc_reg       <= 16'h0000;
            sp_reg       <= SP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_kind_reg <= cur_kind_next;
            a_reg        <= a_next;
            x_reg        <= x_next;
            p_reg        <= p_next;
            pc_reg       <= pc_next;
            sp_reg       <= sp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        vlo_reg     <= vlo_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= mem[mem_addr];
    end

endmodule

// ===== src/mos6502_subset_execute.sv =====
// Throughput: register ops, stores and pokes 1 item/cycle while the output is not stalled;
// LDA from memory and peek wait for their read data before the next instruction is taken,
// and BRK for its three stack writes and two vector reads on the one memory port.
// A 4-entry queue decouples input acceptance from execution.
// Reset (aresetn low, synchronous): A=0, X=0, P=0x24, PC=0, SP=0xFD, Y=0, queue empty;
// memory contents are not cleared.
module mos6502_subset_execute (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wvalid,
    output logic                           cfg_wready,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: opcode[2:0], mode[5:3], operand[21:6], host_data[29:22], zero pad
    input  logic [m6502_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: acc[7:0], x_reg[15:8], flags[23:16], prog_counter[39:24],
    //        stack_ptr[47:40], read_byte[55:48], fault[56], zero pad
    output logic [m6502_pkg::M_DATA_W-1:0] m_tdata
);
    import m6502_pkg::*;

    logic [7:0] index_y_reg, index_y_next;
    logic       q_full, q_push, q_pop, q_valid;
    uop_t       push_uop, head_uop;

    assign cfg_wready   = 1'b1;
    assign index_y_next = (cfg_wvalid && cfg_wready) ? cfg_wdata : index_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) index_y_reg <= 8'h00;
        else          index_y_reg <= index_y_next;
    end

    m6502_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_uop    (push_uop)
    );

    m6502_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_uop   (push_uop),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_uop   (head_uop)
    );

    m6502_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .index_y  (index_y_reg),
        .q_valid  (q_valid),
        .q_uop    (head_uop),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== dv/mos6502_subset_execute_tb.sv =====
// Testbench for mos6502_subset_execute: directed table plus random streams against a predictor.
module mos6502_subset_execute_tb;
    import m6502_pkg::*;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  flags;
        logic [15:0] pc;
        logic [7:0]  sp;
        logic [7:0]  rbyte;
        logic        fault;
    } cpu_view_t;

    typedef struct packed {
        opcode_t     op;
        logic [2:0]  mode;
        logic [15:0] operand;
        logic [7:0]  hdata;
        logic        typed;
        cpu_view_t   want;
    } instr_row_t;

    localparam int DIR_ROWS     = 26;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 385;
    localparam int HOLDOFF_AT   = 600;
    localparam int HOLDOFF_LEN  = 300;

    logic                 aclk;
    logic                 aresetn    = 1'b0;
    logic                 cfg_wvalid = 1'b0;
    logic                 cfg_wready;
    logic [7:0]           cfg_wdata  = 8'h00;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    mos6502_subset_execute dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    logic [7:0]  a_mdl, x_mdl, p_mdl, sp_mdl, y_mdl;
    logic [15:0] pc_mdl;
    logic [7:0]  mem_img [0:65535];
    bit          mem_set [0:65535];
    logic [15:0] filled_addrs [$];
    logic [7:0]  zp_filled [$];

    cpu_view_t   pending_views [$];
    cpu_view_t   seen, oldest;
    instr_row_t  dir_tab [0:DIR_ROWS-1];
    logic [7:0]  y_plan [0:PHASES-1];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  n_items      = 0;
    int  n_brk        = 0;
    int  n_fault      = 0;
    int  stall_left   = 0;
    bit  held_off     = 1'b0;
    bit  steady       = 1'b0;

    function automatic instr_row_t mk(input opcode_t op, input logic [2:0] mode,
                                      input logic [15:0] opnd, input logic [7:0] hd);
        instr_row_t r;
        r = '0;
        r.op = op;
        r.mode = mode;
        r.operand = opnd;
        r.hdata = hd;
        return r;
    endfunction

    function automatic instr_row_t mkv(input opcode_t op, input logic [2:0] mode,
                                       input logic [15:0] opnd, input logic [7:0] hd,
                                       input logic [7:0] acc, input logic [7:0] x,
                                       input logic [7:0] p, input logic [15:0] pc,
                                       input logic [7:0] sp, input logic [7:0] rb,
                                       input logic f);
        instr_row_t r;
        r = mk(op, mode, opnd, hd);
        r.typed = 1'b1;
        r.want = '{acc: acc, x: x, flags: p, pc: pc, sp: sp, rbyte: rb, fault: f};
        return r;
    endfunction

    function automatic void store_byte(input logic [15:0] addr, input logic [7:0] v);
        if (!mem_set[addr]) begin
            mem_set[addr] = 1'b1;
            filled_addrs.push_back(addr);
            if (addr < 16'h0100)
                zp_filled.push_back(addr[7:0]);
        end
        mem_img[addr] = v;
    endfunction

    function automatic void stack_push(input logic [7:0] v);
        store_byte({STACK_PAGE, sp_mdl}, v);
        sp_mdl = sp_mdl - 8'd1;
    endfunction

    function automatic logic [7:0] with_zn(input logic [7:0] v);
        return (p_mdl & ~(FLAG_Z | FLAG_N)) | ((v == 8'h00) ? FLAG_Z : 8'h00)
               | (v[7] ? FLAG_N : 8'h00);
    endfunction

    function automatic cpu_view_t run_instruction(input instr_row_t it);
        cpu_view_t   v;
        logic [15:0] ea;
        logic [15:0] ret;
        logic        ok;
        v = '0;
        ok = 1'b1;
        ea = 16'h0000;
        case (it.mode)
            MODE_ZP:   ea = {8'h00, it.operand[7:0]};
            MODE_ABS:  ea = it.operand;
            MODE_ABSX: ea = it.operand + {8'h00, x_mdl};
            MODE_ABSY: ea = it.operand + {8'h00, y_mdl};
            default:   ok = 1'b0;
        endcase
        case (it.op)
            OP_LDA: begin
                if (it.mode == MODE_IMM) begin
                    a_mdl = it.operand[7:0];
                    p_mdl = with_zn(a_mdl);
                end else if (ok) begin
                    a_mdl = mem_img[ea];
                    p_mdl = with_zn(a_mdl);
                end else begin
                    v.fault = 1'b1;
                end
            end
            OP_STA: begin
                if (it.mode != MODE_IMM && ok)
                    store_byte(ea, a_mdl);
                else
                    v.fault = 1'b1;
            end
            OP_TAX: begin
                x_mdl = a_mdl;
                p_mdl = with_zn(x_mdl);
            end
            OP_INX: begin
                x_mdl = x_mdl + 8'd1;
                p_mdl = with_zn(x_mdl);
            end
            OP_BRK: begin
                ret = pc_mdl + 16'd2;
                stack_push(ret[15:8]);
                stack_push(ret[7:0]);
                p_mdl = p_mdl | FLAG_B | FLAG_I;
                stack_push(p_mdl | PUSH_P_SET);
                pc_mdl = {mem_img[VEC_HI], mem_img[VEC_LO]};
            end
            OP_POKE: store_byte(it.operand, it.hdata);
            OP_PEEK: v.rbyte = mem_img[it.operand];
            default: ;
        endcase
        v.acc = a_mdl;
        v.x = x_mdl;
        v.flags = p_mdl;
        v.pc = pc_mdl;
        v.sp = sp_mdl;
        return v;
    endfunction

    task automatic load_index_y(input logic [7:0] val);
        cfg_wvalid <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_wready) @(posedge aclk);
        cfg_wvalid <= 1'b0;
        y_mdl = val;
    endtask

    task automatic issue(input instr_row_t it);
        cpu_view_t pred;
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.hdata, it.operand, it.mode, it.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = run_instruction(it);
        pending_views.push_back(it.typed ? it.want : pred);
        n_items++;
        if (it.op == OP_BRK) n_brk++;
        if (pred.fault) n_fault++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{acc: m_tdata[7:0], x: m_tdata[15:8], flags: m_tdata[23:16],
                     pc: m_tdata[39:24], sp: m_tdata[47:40], rbyte: m_tdata[55:48],
                     fault: m_tdata[56]};
            results_seen++;
            if (pending_views.size() == 0) begin
                $error("result transfer with nothing pending: %h", m_tdata);
                mismatches++;
            end else begin
                oldest = pending_views.pop_front();
                check_field("acc", 16'(oldest.acc), 16'(seen.acc));
                check_field("x_reg", 16'(oldest.x), 16'(seen.x));
                check_field("flags", 16'(oldest.flags), 16'(seen.flags));
                check_field("prog_counter", oldest.pc, seen.pc);
                check_field("stack_ptr", 16'(oldest.sp), 16'(seen.sp));
                check_field("read_byte", 16'(oldest.rbyte), 16'(seen.rbyte));
                check_field("fault", 16'(oldest.fault), 16'(seen.fault));
            end
        end
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= HOLDOFF_AT) begin
                held_off = 1'b1;
                stall_left = HOLDOFF_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 9);
            end
        end
    end

    initial begin
        #8000000;
        $display("mos6502_subset_execute_tb: FAIL");
        $finish;
    end

    initial begin
        instr_row_t  row;
        logic [15:0] tgt;
        int          pick;
        int          sub;
        a_mdl = 8'h00;
        x_mdl = 8'h00;
        p_mdl = P_RESET;
        pc_mdl = 16'h0000;
        sp_mdl = SP_RESET;
        y_mdl = 8'h00;
        y_plan = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h01};
        y_plan[1] = 8'($urandom);
        y_plan[3] = 8'($urandom);
        dir_tab = '{
            mkv(OP_TAX,  MODE_IMM,  16'h0000, 8'h00, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b0),
            mkv(OP_LDA,  MODE_IMM,  16'hFF80, 8'h00, 8'h80, 8'h00, 8'hA4, 16'h0, 8'hFD, 8'h0, 1'b0),
            mkv(OP_LDA,  MODE_IMM,  16'h0100, 8'hFF, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b0),
            mkv(OP_STA,  MODE_IMM,  16'h1234, 8'h55, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b1),
            mkv(OP_LDA,  3'd5,      16'h00FF, 8'h00, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b1),
            mkv(OP_STA,  3'd7,      16'hFFFF, 8'hAA, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b1),
            mkv(OP_NONE, 3'd6,      16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h26, 16'h0, 8'hFD, 8'h0, 1'b0),
            mk(OP_POKE,  MODE_IMM,  16'hFFFE, 8'h34),
            mk(OP_POKE,  MODE_ABSY, 16'hFFFF, 8'h12),
            mk(OP_POKE,  MODE_ZP,   16'h0000, 8'hFF),
            mk(OP_POKE,  3'd7,      16'h00FF, 8'h7F),
            mk(OP_PEEK,  MODE_ABS,  16'hFFFF, 8'hC3),
            mk(OP_LDA,   MODE_ZP,   16'hAB00, 8'h00),
            mk(OP_LDA,   MODE_ABS,  16'h00FF, 8'h00),
            mk(OP_LDA,   MODE_IMM,  16'h00FF, 8'h00),
            mk(OP_TAX,   3'd5,      16'hFFFF, 8'hFF),
            mk(OP_INX,   3'd6,      16'h8000, 8'h80),
            mk(OP_INX,   MODE_ABSX, 16'h0001, 8'h01),
            mk(OP_LDA,   MODE_ABSX, 16'hFFFF, 8'h00),
            mk(OP_LDA,   MODE_ABSY, 16'hFF01, 8'h00),
            mk(OP_STA,   MODE_ZP,   16'hFF80, 8'h00),
            mk(OP_STA,   MODE_ABSX, 16'hFFFF, 8'h00),
            mk(OP_STA,   MODE_ABSY, 16'h1234, 8'h00),
            mk(OP_BRK,   MODE_ABSX, 16'h5A5A, 8'h5A),
            mk(OP_BRK,   3'd7,      16'hA5A5, 8'hA5),
            mk(OP_PEEK,  MODE_IMM,  16'h01FD, 8'h00)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_index_y(8'hFF);
        for (int i = 0; i < DIR_ROWS; i++)
            issue(dir_tab[i]);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            while (pending_views.size() != 0) @(posedge aclk);
            load_index_y(y_plan[ph]);
            steady = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                row = '0;
                row.hdata = 8'($urandom);
                row.mode = 3'($urandom);
                row.operand = 16'($urandom);
                pick = $urandom_range(0, 99);
                sub = $urandom_range(0, 9);
                tgt = filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
                if (pick < 25) begin
                    row.op = OP_LDA;
                    if (sub < 2) begin
                        row.mode = MODE_IMM;
                    end else if (sub == 9) begin
                        row.mode = 3'($urandom_range(5, 7));
                    end else begin
                        row.mode = 3'($urandom_range(1, 4));
                        case (row.mode)
                            MODE_ZP:   row.operand = {row.operand[15:8],
                                           zp_filled[$urandom_range(0, zp_filled.size() - 1)]};
                            MODE_ABS:  row.operand = tgt;
                            MODE_ABSX: row.operand = tgt - {8'h00, x_mdl};
                            default:   row.operand = tgt - {8'h00, y_mdl};
                        endcase
                    end
                end else if (pick < 40) begin
                    row.op = OP_STA;
                    if (sub == 9)
                        row.mode = 3'($urandom_range(5, 7));
                    else if (sub == 8)
                        row.mode = MODE_IMM;
                    else
                        row.mode = 3'($urandom_range(1, 4));
                end else if (pick < 48) begin
                    row.op = OP_TAX;
                end else if (pick < 56) begin
                    row.op = OP_INX;
                end else if (pick < 61) begin
                    row.op = OP_BRK;
                end else if (pick < 81) begin
                    row.op = OP_POKE;
                end else if (pick < 97) begin
                    row.op = OP_PEEK;
                    row.operand = tgt;
                end else begin
                    row.op = OP_NONE;
                end
                issue(row);
            end
            s_tvalid <= 1'b0;
        end

        steady = 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d instructions (%0d BRK, %0d faulting) under %0d Y settings",
                 n_items, n_brk, n_fault, PHASES + 1);
        $display("Checked %0d results, including one %0d-cycle receiver hold-off",
                 results_seen, HOLDOFF_LEN);
        if (mismatches == 0)
            $display("mos6502_subset_execute_tb: PASS");
        else
            $display("mos6502_subset_execute_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/m6502_pkg.sv
src/m6502_front.sv
src/m6502_queue.sv
src/m6502_back.sv
src/mos6502_subset_execute.sv
dv/mos6502_subset_execute_tb.sv
